FILE: rtl/mppd_pkg.sv
// Package for the two-phase PD position controller.
// Holds the register map, the reset values and the fixed constants.
// No dependencies.
package mppd_pkg;

	// Default widths of position and speed values
	localparam int POSITION_WIDTH_DEF = 32;
	localparam int SPEED_WIDTH_DEF    = 16;

	// Configuration port shape
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 32;
	localparam int GAIN_WIDTH      = 16;
	localparam int MOTOR_ID_WIDTH  = 2;

	// Register map
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_TARGET_POSITION  = 3'd0,
		REG_KP_GAIN          = 3'd1,
		REG_KD_GAIN          = 3'd2,
		REG_COARSE_THRESHOLD = 3'd3,
		REG_MIN_SPEED        = 3'd4,
		REG_MAX_SPEED        = 3'd5,
		REG_MOTOR_SELECT     = 3'd6
	} cfg_index_t;

	// Register reset values
	localparam logic [GAIN_WIDTH-1:0]     KP_GAIN_RST          = 16'd26;
	localparam logic [GAIN_WIDTH-1:0]     KD_GAIN_RST          = 16'd2560;
	localparam logic [GAIN_WIDTH-1:0]     COARSE_THRESHOLD_RST = 16'd200;
	localparam logic [GAIN_WIDTH-1:0]     MIN_SPEED_RST        = 16'd100;
	localparam logic [GAIN_WIDTH-1:0]     MAX_SPEED_RST        = 16'd2000;
	localparam logic [MOTOR_ID_WIDTH-1:0] MOTOR_SELECT_RST     = 2'd0;

	// Drive speed of the coarse phase and stop window around the target
	localparam int FULL_SPEED = 2000;
	localparam int DEADBAND   = 3;

endpackage

FILE: rtl/mppd_sample_if.sv
// Input channel of the PD position controller: one encoder sample per beat.
// Depends on mppd_pkg for the default position width.
interface mppd_sample_if #(
	parameter int POSITION_WIDTH = mppd_pkg::POSITION_WIDTH_DEF
);
	logic                             valid;
	logic                             ready;
	logic signed [POSITION_WIDTH-1:0] measured_position;

	modport source (output valid, output measured_position, input ready);
	modport sink   (input valid, input measured_position, output ready);
endinterface

FILE: rtl/mppd_command_if.sv
// Output channel of the PD position controller: one motor command per beat.
// Depends on mppd_pkg for the default speed and motor id widths.
interface mppd_command_if #(
	parameter int SPEED_WIDTH = mppd_pkg::SPEED_WIDTH_DEF
);
	logic                                valid;
	logic                                ready;
	logic [mppd_pkg::MOTOR_ID_WIDTH-1:0] motor_id;
	logic                                direction;
	logic [SPEED_WIDTH-1:0]              speed;
	logic                                done_res;

	modport source (output valid, output motor_id, output direction, output speed,
		output done_res, input ready);
	modport sink   (input valid, input motor_id, input direction, input speed,
		input done_res, output ready);
endinterface

FILE: rtl/motor_position_pd_two_phase.sv
// Two-phase PD position controller, top level.
// Depends on mppd_pkg, mppd_sample_if and mppd_command_if.
//
// Usage:
//   sample  : valid/ready channel, one signed encoder position per beat.
//   command : valid/ready channel, one motor command per beat (motor id,
//             direction, speed, done).
//   cfg_*   : write-only register port; write while no sample is in flight.
//             Writing the target position restarts the coarse phase.
// Every sample gives exactly one command, in order. An accepted beat is loaded
// into the input register, then passes the error stage, the multiply stage and
// the sum and clamp stage into the output register, from which it is presented.
// One sample can be taken every cycle unless the pipeline is stalled; the four
// registers hold up to four samples, and each stage frees up as soon as the one
// after it moves on. When the receiver stalls, the pipeline fills and then
// sample.ready drops; results wait in the output register and nothing is lost.
// Reset (arst_n low) empties the pipeline, loads the register defaults,
// clears the previous error and returns to the first-sample phase.
module motor_position_pd_two_phase #(
	parameter int POSITION_WIDTH = mppd_pkg::POSITION_WIDTH_DEF,
	parameter int SPEED_WIDTH    = mppd_pkg::SPEED_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mppd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [mppd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	mppd_sample_if.sink                          sample,
	mppd_command_if.source                       command
);

	localparam int PW = POSITION_WIDTH;
	localparam int SW = SPEED_WIDTH;
	localparam int GW = mppd_pkg::GAIN_WIDTH;

	// Error limits after saturation: +-(2^(PW-1)-1), in PW+1 bits
	localparam logic signed [PW:0] ERR_LIM  = {2'b00, {(PW-1){1'b1}}};
	localparam logic signed [PW:0] ERR_NLIM = {2'b11, {(PW-2){1'b0}}, 1'b1};
	localparam logic [SW-1:0] SPD_TOP = {SW{1'b1}};
	localparam logic [SW-1:0] FULL_SAT =
		(mppd_pkg::FULL_SPEED > (2**SW - 1)) ? SPD_TOP : SW'(mppd_pkg::FULL_SPEED);

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_COARSE = 2'd1,
		PH_PD     = 2'd2
	} phase_t;

	// Configuration registers
	logic signed [PW-1:0]                target_q;
	logic [GW-1:0]                       kp_q;
	logic [GW-1:0]                       kd_q;
	logic [GW-1:0]                       coarse_thr_q;
	logic [GW-1:0]                       min_speed_q;
	logic [GW-1:0]                       max_speed_q;
	logic [mppd_pkg::MOTOR_ID_WIDTH-1:0] motor_sel_q;

	// Controller state
	phase_t               phase_q;
	logic signed [PW-1:0] prev_err_q;

	// Pipeline valids and payload
	logic                 v_s1, v_s2, v_s3, vo_q;
	logic signed [PW-1:0] pos_s1;
	logic                 coarse_s2, stop_s2, dir_s2;
	logic [PW-2:0]        mag_s2;
	logic signed [PW:0]   d_s2;
	logic                 coarse_s3, stop_s3, dir_s3;
	logic [PW+14:0]       prod_kp_s3;
	logic signed [PW+16:0] prod_kd_s3;
	logic [mppd_pkg::MOTOR_ID_WIDTH-1:0] motor_id_q;
	logic                 dir_q;
	logic [SW-1:0]        speed_q;
	logic                 done_q;

	// Stage flow control
	logic free_o, free3, free2, free1;

	// Stage 1 logic
	logic signed [PW:0]   err_full;
	logic signed [PW-1:0] err_sat;
	logic signed [PW-1:0] err_negated;
	logic                 err_neg;
	logic [PW-2:0]        mag;
	logic signed [PW-1:0] prev_err;
	logic signed [PW:0]   diff;
	logic signed [PW:0]   d_adj;
	logic                 coarse;
	logic                 stop;

	// Stage 2 and 3 logic
	logic [PW+14:0]        prod_kp;
	logic signed [PW+16:0] prod_kd;
	logic signed [PW+17:0] pd_sum;
	logic [PW+8:0]         pd_shift;
	logic [GW-1:0]         pd_speed;
	logic [SW-1:0]         pd_speed_sat;
	logic [SW-1:0]         speed_next;

	assign free_o = !vo_q || command.ready;
	assign free3  = !v_s3 || free_o;
	assign free2  = !v_s2 || free3;
	assign free1  = !v_s1 || free2;
	assign sample.ready = free1;

	// Error, magnitude, derivative and phase decision
	always_comb begin
		err_full = {target_q[PW-1], target_q} - {pos_s1[PW-1], pos_s1};
		if (err_full > ERR_LIM) begin
			err_sat = ERR_LIM[PW-1:0];
		end else if (err_full < ERR_NLIM) begin
			err_sat = ERR_NLIM[PW-1:0];
		end else begin
			err_sat = err_full[PW-1:0];
		end
		err_neg     = err_sat[PW-1];
		err_negated = -err_sat;
		mag         = err_neg ? err_negated[PW-2:0] : err_sat[PW-2:0];
		prev_err    = (phase_q == PH_FIRST) ? err_sat : prev_err_q;
		diff        = {err_sat[PW-1], err_sat} - {prev_err[PW-1], prev_err};
		d_adj       = err_neg ? -diff : diff;
		coarse      = (phase_q != PH_PD) && ({1'b0, mag} > PW'(coarse_thr_q));
		stop        = !coarse && ({1'b0, mag} <= PW'(mppd_pkg::DEADBAND));
	end

	// Proportional and derivative products
	always_comb begin
		prod_kp = (PW+15)'(mag_s2) * (PW+15)'(kp_q);
		prod_kd = signed'({{16{d_s2[PW]}}, d_s2}) * signed'({{(PW+1){1'b0}}, kd_q});
	end

	// Sum, scale and clamp
	always_comb begin
		pd_sum   = signed'({3'b000, prod_kp_s3}) + {prod_kd_s3[PW+16], prod_kd_s3};
		pd_shift = pd_sum[PW+16:8];
		if (pd_sum[PW+17]) begin
			pd_speed = min_speed_q;
		end else if (pd_shift < (PW+9)'(min_speed_q)) begin
			pd_speed = min_speed_q;
		end else if (pd_shift > (PW+9)'(max_speed_q)) begin
			pd_speed = max_speed_q;
		end else begin
			pd_speed = pd_shift[GW-1:0];
		end
		if (pd_speed > GW'(SPD_TOP)) begin
			pd_speed_sat = SPD_TOP;
		end else begin
			pd_speed_sat = pd_speed[SW-1:0];
		end
		if (coarse_s3) begin
			speed_next = FULL_SAT;
		end else if (stop_s3) begin
			speed_next = '0;
		end else begin
			speed_next = pd_speed_sat;
		end
	end

	// Configuration writes; a new target restarts the coarse phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= '0;
			kp_q         <= mppd_pkg::KP_GAIN_RST;
			kd_q         <= mppd_pkg::KD_GAIN_RST;
			coarse_thr_q <= mppd_pkg::COARSE_THRESHOLD_RST;
			min_speed_q  <= mppd_pkg::MIN_SPEED_RST;
			max_speed_q  <= mppd_pkg::MAX_SPEED_RST;
			motor_sel_q  <= mppd_pkg::MOTOR_SELECT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mppd_pkg::REG_TARGET_POSITION:  target_q     <= cfg_data[PW-1:0];
				mppd_pkg::REG_KP_GAIN:          kp_q         <= cfg_data[GW-1:0];
				mppd_pkg::REG_KD_GAIN:          kd_q         <= cfg_data[GW-1:0];
				mppd_pkg::REG_COARSE_THRESHOLD: coarse_thr_q <= cfg_data[GW-1:0];
				mppd_pkg::REG_MIN_SPEED:        min_speed_q  <= cfg_data[GW-1:0];
				mppd_pkg::REG_MAX_SPEED:        max_speed_q  <= cfg_data[GW-1:0];
				mppd_pkg::REG_MOTOR_SELECT:
					motor_sel_q <= cfg_data[mppd_pkg::MOTOR_ID_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Phase and previous error advance as a sample leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			prev_err_q <= '0;
		end else if (cfg_we && (cfg_index == mppd_pkg::REG_TARGET_POSITION)) begin
			phase_q <= PH_FIRST;
		end else if (v_s1 && free2) begin
			phase_q    <= coarse ? PH_COARSE : PH_PD;
			prev_err_q <= err_sat;
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (free1) v_s1 <= sample.valid;
			if (free2) v_s2 <= v_s1;
			if (free3) v_s3 <= v_s2;
			if (free_o) vo_q <= v_s3;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (free1 && sample.valid) begin
			pos_s1 <= sample.measured_position;
		end
		if (free2 && v_s1) begin
			coarse_s2 <= coarse;
			stop_s2   <= stop;
			dir_s2    <= err_neg;
			mag_s2    <= mag;
			d_s2      <= d_adj;
		end
		if (free3 && v_s2) begin
			coarse_s3  <= coarse_s2;
			stop_s3    <= stop_s2;
			dir_s3     <= dir_s2 && !stop_s2;
			prod_kp_s3 <= prod_kp;
			prod_kd_s3 <= prod_kd;
		end
		if (free_o && v_s3) begin
			motor_id_q <= motor_sel_q;
			dir_q      <= dir_s3;
			speed_q    <= speed_next;
			done_q     <= stop_s3;
		end
	end

	assign command.valid     = vo_q;
	assign command.motor_id  = motor_id_q;
	assign command.direction = dir_q;
	assign command.speed     = speed_q;
	assign command.done_res  = done_q;

endmodule

FILE: tb/tb_motor_position_pd_two_phase.sv
// Testbench for the two-phase PD position controller.
// Predicts each motor command from the encoder samples it drives and checks
// every command beat. Depends on mppd_pkg, mppd_sample_if and mppd_command_if.
module tb_motor_position_pd_two_phase;

	localparam int     PIPE_LATENCY = 4;
	localparam int     CYCLE_LIMIT  = 200000;
	localparam longint ERR_LIMIT    = 64'sd2147483647;
	localparam longint POS_MIN      = -64'sd2147483648;
	localparam longint SPEED_TOP    = 64'sd65535;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_COARSE = 2'd1,
		PH_PD     = 2'd2
	} ctrl_phase_t;

	typedef struct packed {
		logic [mppd_pkg::MOTOR_ID_WIDTH-1:0] motor_id;
		logic                                direction;
		logic [15:0]                         speed;
		logic                                done_res;
	} motor_cmd_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_we;
	logic [mppd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [mppd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

	mppd_sample_if  sample_ch();
	mppd_command_if command_ch();

	motor_position_pd_two_phase u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.command   (command_ch)
	);

	// Controller state and register copy held by the predictor
	logic signed [31:0]                  tgt_pos;
	logic [15:0]                         kp;
	logic [15:0]                         kd;
	logic [15:0]                         coarse_thr;
	logic [15:0]                         speed_min;
	logic [15:0]                         speed_max;
	logic [mppd_pkg::MOTOR_ID_WIDTH-1:0] motor_sel;
	longint                              last_err;
	ctrl_phase_t                         ctrl_phase;

	motor_cmd_t pending_commands[$];
	int         error_count  = 0;
	int         cycle_count  = 0;
	int         items_sent   = 0;
	int         tx_idle_pct  = 0;
	int         rx_stall_pct = 0;
	int         hold_left    = 0;

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Work out the command for one sample and advance the controller state
	function automatic motor_cmd_t predict_command(input logic signed [31:0] pos);
		motor_cmd_t c;
		longint     err;
		longint     mag;
		longint     prev;
		longint     d;
		longint     sum;
		longint     spd;
		err = longint'(tgt_pos) - longint'(pos);
		if (err > ERR_LIMIT)
			err = ERR_LIMIT;
		if (err < -ERR_LIMIT)
			err = -ERR_LIMIT;
		mag = (err < 0) ? -err : err;
		prev = (ctrl_phase == PH_FIRST) ? err : last_err;
		c.motor_id  = motor_sel;
		c.direction = (err < 0);
		c.done_res  = 1'b0;
		if (ctrl_phase != PH_PD && mag > longint'(coarse_thr)) begin
			spd = mppd_pkg::FULL_SPEED;
			ctrl_phase = PH_COARSE;
		end else begin
			ctrl_phase = PH_PD;
			if (mag > mppd_pkg::DEADBAND) begin
				d = err - prev;
				if (err < 0)
					d = -d;
				sum = mag * longint'(kp) + d * longint'(kd);
				if (sum < 0) begin
					spd = longint'(speed_min);
				end else begin
					spd = sum >>> 8;
					if (spd < longint'(speed_min))
						spd = longint'(speed_min);
					else if (spd > longint'(speed_max))
						spd = longint'(speed_max);
				end
			end else begin
				// Inside the deadband: stop and flag done
				spd = 0;
				c.direction = 1'b0;
				c.done_res  = 1'b1;
			end
		end
		if (spd > SPEED_TOP)
			spd = SPEED_TOP;
		c.speed = spd[15:0];
		last_err = err;
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < 40)
			$display("MISMATCH cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Cycle counter and run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off counted down here
	always @(posedge clk) begin
		if (hold_left > 0) begin
			command_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			command_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Predict on every accepted sample beat
	always @(posedge clk) begin
		if (arst_n && sample_ch.valid && sample_ch.ready)
			pending_commands.push_back(predict_command(sample_ch.measured_position));
	end

	// Check every accepted command beat against the oldest prediction
	always @(posedge clk) begin : check_beat
		motor_cmd_t want;
		if (arst_n && command_ch.valid && command_ch.ready) begin
			if (pending_commands.size() == 0) begin
				report_mismatch("command beat with no sample outstanding");
			end else begin
				want = pending_commands.pop_front();
				if (command_ch.motor_id !== want.motor_id)
					report_mismatch($sformatf("motor_id %0d, want %0d",
						command_ch.motor_id, want.motor_id));
				if (command_ch.direction !== want.direction)
					report_mismatch($sformatf("direction %0d, want %0d",
						command_ch.direction, want.direction));
				if (command_ch.speed !== want.speed)
					report_mismatch($sformatf("speed %0d, want %0d",
						command_ch.speed, want.speed));
				if (command_ch.done_res !== want.done_res)
					report_mismatch($sformatf("done_res %0d, want %0d",
						command_ch.done_res, want.done_res));
			end
		end
	end

	// Offer one sample after a random gap and hold it until taken
	task automatic send_sample(input logic signed [31:0] pos);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.measured_position <= pos;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Drop valid and let every outstanding command drain
	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_commands.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// Write one register, with junk above its width, and mirror it
	task automatic write_reg(input mppd_pkg::cfg_index_t idx, input logic [31:0] value);
		logic [31:0] junk;
		logic [31:0] data;
		junk = $urandom;
		if (idx == mppd_pkg::REG_TARGET_POSITION)
			data = value;
		else if (idx == mppd_pkg::REG_MOTOR_SELECT)
			data = {junk[31:2], value[1:0]};
		else
			data = {junk[31:16], value[15:0]};
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mppd_pkg::REG_TARGET_POSITION: begin
				tgt_pos    = value;
				ctrl_phase = PH_FIRST;
			end
			mppd_pkg::REG_KP_GAIN:          kp = value[15:0];
			mppd_pkg::REG_KD_GAIN:          kd = value[15:0];
			mppd_pkg::REG_COARSE_THRESHOLD: coarse_thr = value[15:0];
			mppd_pkg::REG_MIN_SPEED:        speed_min = value[15:0];
			mppd_pkg::REG_MAX_SPEED:        speed_max = value[15:0];
			mppd_pkg::REG_MOTOR_SELECT:     motor_sel = value[1:0];
			default: ;
		endcase
	endtask

	// Pick a 16-bit setting, now and then at one of its extremes
	function automatic logic [31:0] pick_setting(input int lo, input int hi);
		int roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return 32'd0;
		if (roll == 1)
			return 32'd65535;
		return $urandom_range(hi, lo);
	endfunction

	task automatic randomize_settings();
		if ($urandom_range(3) != 0) begin
			case ($urandom_range(3))
				0:       write_reg(mppd_pkg::REG_TARGET_POSITION, 32'h7FFF_FFFF);
				1:       write_reg(mppd_pkg::REG_TARGET_POSITION, 32'h8000_0000);
				2:       write_reg(mppd_pkg::REG_TARGET_POSITION, $urandom);
				default: write_reg(mppd_pkg::REG_TARGET_POSITION,
					$urandom_range(200000, 0) - 100000);
			endcase
		end
		if ($urandom_range(1))
			write_reg(mppd_pkg::REG_KP_GAIN, pick_setting(0, 512));
		if ($urandom_range(1))
			write_reg(mppd_pkg::REG_KD_GAIN, pick_setting(0, 4096));
		if ($urandom_range(1))
			write_reg(mppd_pkg::REG_COARSE_THRESHOLD, pick_setting(0, 1000));
		if ($urandom_range(1))
			write_reg(mppd_pkg::REG_MIN_SPEED, pick_setting(0, 300));
		if ($urandom_range(1))
			write_reg(mppd_pkg::REG_MAX_SPEED, pick_setting(300, 4000));
		if ($urandom_range(1))
			write_reg(mppd_pkg::REG_MOTOR_SELECT, $urandom_range(3));
	endtask

	// One approach: start off target, close in, settle within the deadband;
	// a few samples are replaced by noise
	task automatic run_approach(input bit allow_settings);
		longint             off;
		longint             v;
		int                 steps;
		logic signed [31:0] pos;
		if (allow_settings && $urandom_range(1)) begin
			wait_idle();
			randomize_settings();
		end
		steps = $urandom_range(16, 4);
		case ($urandom_range(3))
			0:       off = $urandom_range(300, 0);
			1:       off = $urandom_range(5000, 0);
			2:       off = longint'($signed($urandom));
			default: off = $urandom_range(2 * int'(coarse_thr) + 10, 0);
		endcase
		if ($urandom_range(1))
			off = -off;
		for (int i = 0; i < steps; i++) begin
			if (i >= steps - 2)
				off = int'($urandom_range(6, 0)) - 3;
			v = longint'(tgt_pos) - off;
			if (v > ERR_LIMIT)
				v = ERR_LIMIT;
			if (v < POS_MIN)
				v = POS_MIN;
			pos = v[31:0];
			if ($urandom_range(7) == 0)
				pos = $urandom;
			send_sample(pos);
			off = off * int'($urandom_range(90, 20)) / 100;
			if ($urandom_range(9) == 0)
				off = -off / 2;
		end
	endtask

	// Reset values: coarse drive both ways, PD entry, deadband, error saturation
	task automatic test_reset_defaults();
		tx_idle_pct  = 20;
		rx_stall_pct = 20;
		send_sample(32'sh8000_0000);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sd150);
		send_sample(-32'sd100);
		send_sample(-32'sd20);
		send_sample(-32'sd3);
		send_sample(32'sd3);
		send_sample(32'sd4);
		send_sample(32'sd5000);
	endtask

	// A target write restarts with a zero derivative and the coarse check
	task automatic test_first_sample();
		wait_idle();
		write_reg(mppd_pkg::REG_TARGET_POSITION, 32'd1000);
		send_sample(32'sd900);
		wait_idle();
		write_reg(mppd_pkg::REG_TARGET_POSITION, 32'd1000);
		send_sample(32'sd0);
		send_sample(32'sd998);
	endtask

	// Extreme gains and limits, zero minimum, crossed limits, spare selector
	task automatic test_config_extremes();
		wait_idle();
		write_reg(mppd_pkg::REG_KP_GAIN, 32'd65535);
		write_reg(mppd_pkg::REG_KD_GAIN, 32'd65535);
		write_reg(mppd_pkg::REG_MIN_SPEED, 32'd0);
		write_reg(mppd_pkg::REG_MAX_SPEED, 32'd65535);
		write_reg(mppd_pkg::REG_COARSE_THRESHOLD, 32'd0);
		write_reg(mppd_pkg::REG_MOTOR_SELECT, 32'd3);
		write_reg(mppd_pkg::REG_TARGET_POSITION, 32'h7FFF_FFFF);
		send_sample(32'sh8000_0000);
		send_sample(32'sh7FFF_FFF5);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh7FFF_FC17);
		wait_idle();
		write_reg(mppd_pkg::REG_COARSE_THRESHOLD, 32'd65535);
		write_reg(mppd_pkg::REG_MOTOR_SELECT, 32'd2);
		write_reg(mppd_pkg::REG_TARGET_POSITION, 32'h8000_0000);
		send_sample(32'sh7FFF_FFFF);
		wait_idle();
		write_reg(mppd_pkg::REG_KP_GAIN, 32'd0);
		write_reg(mppd_pkg::REG_KD_GAIN, 32'd0);
		write_reg(mppd_pkg::REG_TARGET_POSITION, 32'd0);
		send_sample(32'sd10);
		wait_idle();
		write_reg(mppd_pkg::REG_KP_GAIN, 32'd256);
		write_reg(mppd_pkg::REG_MIN_SPEED, 32'd500);
		write_reg(mppd_pkg::REG_MAX_SPEED, 32'd300);
		write_reg(mppd_pkg::REG_MOTOR_SELECT, 32'd1);
		send_sample(32'sd100);
		send_sample(32'sd400);
		send_sample(32'sd1000);
	endtask

	// Hold the receiver off so the pipeline fills and stalls the sender,
	// then pause the sender until everything has drained
	task automatic test_backpressure();
		wait_idle();
		write_reg(mppd_pkg::REG_KP_GAIN, mppd_pkg::KP_GAIN_RST);
		write_reg(mppd_pkg::REG_KD_GAIN, mppd_pkg::KD_GAIN_RST);
		write_reg(mppd_pkg::REG_COARSE_THRESHOLD, mppd_pkg::COARSE_THRESHOLD_RST);
		write_reg(mppd_pkg::REG_MIN_SPEED, mppd_pkg::MIN_SPEED_RST);
		write_reg(mppd_pkg::REG_MAX_SPEED, mppd_pkg::MAX_SPEED_RST);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_left    = 80;
		run_approach(1'b0);
		run_approach(1'b0);
		run_approach(1'b0);
		wait_idle();
	endtask

	// Random approaches under each idling pattern
	task automatic test_random_traffic();
		int tx_pct[4];
		int rx_pct[4];
		int stop_at;
		tx_pct = '{0, 63, 0, 20};
		rx_pct = '{0, 0, 63, 20};
		for (int p = 0; p < 4; p++) begin
			tx_idle_pct  = tx_pct[p];
			rx_stall_pct = rx_pct[p];
			stop_at = items_sent + 125;
			while (items_sent < stop_at)
				run_approach(1'b1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.measured_position = '0;
		command_ch.ready = 1'b0;
		tgt_pos    = '0;
		kp         = mppd_pkg::KP_GAIN_RST;
		kd         = mppd_pkg::KD_GAIN_RST;
		coarse_thr = mppd_pkg::COARSE_THRESHOLD_RST;
		speed_min  = mppd_pkg::MIN_SPEED_RST;
		speed_max  = mppd_pkg::MAX_SPEED_RST;
		motor_sel  = mppd_pkg::MOTOR_SELECT_RST;
		last_err   = 0;
		ctrl_phase = PH_FIRST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_first_sample();
		test_config_extremes();
		test_backpressure();
		test_random_traffic();

		wait_idle();
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
